FILE: rtl/core/text_console_engine_assert.svh
// Assertion macros for the text console checker.
`ifndef TEXT_CONSOLE_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_ENGINE_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define TXCON_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define TXCON_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define TXCON_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/txcon_pkg.sv
// Types and constants of the text console engine.
package txcon_pkg;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int TAB_W       = 7;

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;
    localparam logic [6:0] RESET_TAB  = 7'd4;

    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB  = 1'd1;

    typedef enum logic [7:0] {
        S_CLR  = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_TAB  = 8'b0000_0100,
        S_SCRL = 8'b0000_1000,
        S_BLNK = 8'b0001_0000,
        S_RD   = 8'b0010_0000,
        S_DONE = 8'b0100_0000
    } t_state;

endpackage

FILE: rtl/core/text_console_engine.sv
// Text console engine: character cell store, cursor control and scroll sequencer.
// Path: a put of a printable, control or backspace code goes via S_DONE to the output register;
// a read via S_RD and S_DONE; a tab via S_TAB (modulo by subtracting COLUMNS) and S_DONE.
// A put that leaves the bottom row adds a scroll pass through S_SCRL and S_BLNK (one cell a cycle).
// One transaction in flight; o_s_tready is high only while the sequencer is idle.
// Reset (sync, active low): blanks the store in a clear pass (S_CLR), tready low.
module text_console_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // char_code[7:0], read_row[12:8], read_col[19:13], zero pad
    input  logic [txcon_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // command
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // cursor_row[4:0], cursor_col[11:5], cursor_position[22:12], cell_char[30:23],
    // cell_attr[38:31], zero pad
    output logic [txcon_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input  logic                                i_cfg_we,
    input  logic [txcon_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [txcon_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import txcon_pkg::*;

    localparam int NCELL  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(NCELL);
    localparam int CNT_W  = $clog2(NCELL + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int SUM_W  = ((COL_W > TAB_W) ? COL_W : TAB_W) + 1;

    t_state               r_state;
    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic [7:0]           r_attr;
    logic [TAB_W-1:0]     r_tab;
    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_addr;
    logic                 r_wb_pend;
    logic                 r_wb_mem;
    logic [ADDR_W-1:0]    r_wb_addr;
    logic [15:0]          r_wb_data;
    logic [15:0]          r_rdata;
    logic                 r_rd_ok;
    logic [15:0]          r_cell;
    logic                 r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [15:0]          r_mem [NCELL];

    logic                 n_wb_pend;
    logic                 n_wb_mem;
    logic                 accept;
    logic                 in_cmd;
    logic [7:0]           in_ch;
    logic [4:0]           in_rr;
    logic [6:0]           in_rc;
    logic                 rd_ok;
    logic                 last_row;
    logic                 last_col;
    logic [ROW_W-1:0]     put_row;
    logic [COL_W-1:0]     put_col;
    logic                 put_scroll;
    logic                 put_wr;
    logic                 put_blank;
    logic                 put_tab;
    logic [ROW_W-1:0]     m_row;
    logic [COL_W-1:0]     m_col;
    logic [31:0]          lin32;
    logic [ADDR_W-1:0]    lin;
    logic [ADDR_W-1:0]    rd_addr;
    logic [15:0]          wdata;
    logic [31:0]          row32;
    logic [31:0]          col32;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_cmd     = i_s_tuser;
    assign in_ch      = i_s_tdata[7:0];
    assign in_rr      = i_s_tdata[12:8];
    assign in_rc      = i_s_tdata[19:13];
    assign rd_ok      = (32'(in_rr) < ROWS) && (32'(in_rc) < COLUMNS);
    assign last_row   = (r_row == ROW_W'(ROWS - 1));
    assign last_col   = (r_col == COL_W'(COLUMNS - 1));

    // cursor update for a put, evaluated against the current cursor
    always_comb begin
        put_row    = r_row;
        put_col    = r_col;
        put_scroll = 1'b0;
        put_wr     = 1'b0;
        put_blank  = 1'b0;
        put_tab    = 1'b0;
        case (in_ch)
            CH_NL, CH_CR: begin
                put_col = '0;
                if (last_row) begin
                    put_scroll = 1'b1;
                end else begin
                    put_row = r_row + 1'b1;
                end
            end
            CH_TAB: begin
                put_tab = 1'b1;
            end
            CH_BS: begin
                put_wr    = 1'b1;
                put_blank = 1'b1;
                if (r_col == '0) begin
                    put_col = COL_W'(COLUMNS - 1);
                    if (r_row != '0) begin
                        put_row = r_row - 1'b1;
                    end
                end else begin
                    put_col = r_col - 1'b1;
                end
            end
            default: begin
                put_wr = 1'b1;
                if (last_col) begin
                    put_col = '0;
                    if (last_row) begin
                        put_scroll = 1'b1;
                    end else begin
                        put_row = r_row + 1'b1;
                    end
                end else begin
                    put_col = r_col + 1'b1;
                end
            end
        endcase
    end

    // shared row*COLUMNS+col unit: read/write address while idle, cursor position after
    always_comb begin
        m_row = r_row;
        m_col = r_col;
        if (r_state == S_IDLE) begin
            if (in_cmd == CMD_READ) begin
                m_row = ROW_W'(in_rr);
                m_col = COL_W'(in_rc);
            end else if (in_ch == CH_BS) begin
                m_row = put_row;
                m_col = put_col;
            end
        end
    end

    assign lin32   = 32'(m_row) * 32'(COLUMNS) + 32'(m_col);
    assign lin     = lin32[ADDR_W-1:0];
    assign rd_addr = (r_state == S_SCRL) ? ADDR_W'(32'(r_addr) + 32'(COLUMNS)) : lin;
    assign wdata   = r_wb_mem ? r_rdata : r_wb_data;
    assign row32   = 32'(r_row);
    assign col32   = 32'(r_col);

    // writeback request for the cell store
    assign n_wb_mem = (r_state == S_SCRL) && (32'(r_addr) < NCELL - COLUMNS);

    always_comb begin
        case (r_state)
            S_CLR:   n_wb_pend = (32'(r_addr) < NCELL);
            S_IDLE:  n_wb_pend = accept && (in_cmd == CMD_PUT) && put_wr;
            S_SCRL:  n_wb_pend = n_wb_mem;
            S_BLNK:  n_wb_pend = (32'(r_addr) < NCELL);
            default: n_wb_pend = 1'b0;
        endcase
    end

    // cell store: one write port fed from the writeback register, one registered read
    always_ff @(posedge i_clk) begin
        if (r_wb_pend) begin
            r_mem[r_wb_addr] <= wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_attr      <= RESET_ATTR;
            r_tab       <= RESET_TAB;
            r_wb_pend   <= 1'b0;
            r_wb_mem    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wb_pend <= n_wb_pend;
            r_wb_mem  <= n_wb_mem;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ATTR: r_attr <= i_cfg_data[7:0];
                    CFG_TAB:  r_tab  <= i_cfg_data[TAB_W-1:0];
                    default: ;
                endcase
            end

            // the done state reloads the output register itself
            if (r_out_valid && i_m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    if (32'(r_addr) < NCELL) begin
                        r_wb_addr <= r_addr[ADDR_W-1:0];
                        r_wb_data <= {RESET_ATTR, BLANK_CHAR};
                        r_addr    <= r_addr + 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (in_cmd == CMD_READ) begin
                            r_rd_ok <= rd_ok;
                            r_state <= S_RD;
                        end else begin
                            r_cell <= '0;
                            r_row  <= put_row;
                            r_col  <= put_col;
                            r_sum  <= SUM_W'(r_col) + SUM_W'(r_tab);
                            if (put_wr) begin
                                r_wb_addr <= lin;
                                r_wb_data <= {r_attr, put_blank ? BLANK_CHAR : in_ch};
                            end
                            r_addr <= '0;
                            if (put_scroll) begin
                                r_state <= S_SCRL;
                            end else if (put_tab) begin
                                r_state <= S_TAB;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_TAB: begin
                    // modulo by repeated subtract
                    if (32'(r_sum) >= COLUMNS) begin
                        r_sum <= r_sum - SUM_W'(COLUMNS);
                    end else begin
                        r_col   <= r_sum[COL_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_SCRL: begin
                    // read cell a+COLUMNS now, write it to a next cycle
                    if (32'(r_addr) < NCELL - COLUMNS) begin
                        r_wb_addr <= r_addr[ADDR_W-1:0];
                        r_addr    <= r_addr + 1'b1;
                    end else begin
                        r_state <= S_BLNK;
                    end
                end
                S_BLNK: begin
                    if (32'(r_addr) < NCELL) begin
                        r_wb_addr <= r_addr[ADDR_W-1:0];
                        r_wb_data <= {r_attr, BLANK_CHAR};
                        r_addr    <= r_addr + 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_RD: begin
                    r_cell  <= r_rd_ok ? r_rdata : 16'h0000;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {1'b0, r_cell[15:8], r_cell[7:0], lin32[10:0],
                                        col32[6:0], row32[4:0]};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

FILE: rtl/core/txcon_checker.sv
// Port-level checker for the text console engine, bound to the top level.
`include "text_console_engine_assert.svh"

module txcon_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [txcon_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import txcon_pkg::*;

    logic [31:0] row32;
    logic [31:0] col32;
    logic [31:0] pos32;
    logic        small_geom;

    assign row32      = 32'(o_m_tdata[4:0]);
    assign col32      = 32'(o_m_tdata[11:5]);
    assign pos32      = 32'(o_m_tdata[22:12]);
    assign small_geom = (ROWS <= 32) && (COLUMNS <= 128);

    // store clearing keeps the input closed right after reset
    `TXCON_ASSERT_NXT_ALWAYS(a_clr_closed, i_clk, !i_rst_n, !o_s_tready, "input open during clear")

    // one transaction in flight at a time
    `TXCON_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready,
        "input accepted back to back")

    `TXCON_ASSERT_IMP(a_cursor_range, i_clk, i_rst_n, o_m_tvalid,
        (row32 < ROWS) && (col32 < COLUMNS), "cursor outside screen")

    `TXCON_ASSERT_IMP(a_pos_match, i_clk, i_rst_n, o_m_tvalid && small_geom,
        pos32 == ((row32 * COLUMNS + col32) & 32'h7FF), "cursor position mismatch")

    `TXCON_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata), "stalled result changed")

endmodule

bind text_console_engine txcon_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_txcon_checker (.*);

FILE: test/tb_text_console_engine.sv
// Testbench for the text console engine: random streams of put/read commands checked against a cell-level predictor.
`timescale 1ns / 1ps

module tb_text_console_engine;
    import txcon_pkg::*;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;

    typedef struct {
        logic       cmd;
        logic [7:0] code;
        logic [4:0] rd_row;
        logic [6:0] rd_col;
    } t_console_cmd;

    typedef struct {
        logic [4:0]  row;
        logic [6:0]  col;
        logic [10:0] pos;
        logic [7:0]  ch;
        logic [7:0]  attr;
    } t_cursor_report;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    text_console_engine #(
        .COLUMNS(COLS),
        .ROWS   (ROWS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // predictor state
    logic [7:0] scr_char [CELLS];
    logic [7:0] scr_attr [CELLS];
    logic [4:0] crs_row;
    logic [6:0] crs_col;
    logic [7:0] attr_reg;
    logic [6:0] tab_reg;

    t_console_cmd   pending_cmds_q [$];
    t_cursor_report cursor_reports_q [$];
    t_console_cmd   drv_cmd;
    int             err_count = 0;
    int             results_seen = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;
    bit             no_gaps = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic flag_error(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void store_cell(int r, int c, logic [7:0] ch);
        scr_char[r * COLS + c] = ch;
        scr_attr[r * COLS + c] = attr_reg;
    endfunction

    function automatic void next_line();
        if (crs_row == ROWS - 1) begin
            for (int i = 0; i < CELLS - COLS; i++) begin
                scr_char[i] = scr_char[i + COLS];
                scr_attr[i] = scr_attr[i + COLS];
            end
            for (int c = 0; c < COLS; c++) store_cell(ROWS - 1, c, BLANK_CHAR);
        end else begin
            crs_row++;
        end
    endfunction

    function automatic t_cursor_report console_step(t_console_cmd c);
        t_cursor_report rep;
        rep.ch   = '0;
        rep.attr = '0;
        if (c.cmd == CMD_PUT) begin
            if (c.code == CH_NL || c.code == CH_CR) begin
                crs_col = '0;
                next_line();
            end else if (c.code == CH_TAB) begin
                crs_col = 7'((int'(crs_col) + int'(tab_reg)) % COLS);
            end else if (c.code == CH_BS) begin
                if (crs_col == 0) begin
                    crs_col = 7'(COLS - 1);
                    if (crs_row != 0) crs_row--;
                end else begin
                    crs_col--;
                end
                store_cell(crs_row, crs_col, BLANK_CHAR);
            end else begin
                store_cell(crs_row, crs_col, c.code);
                if (crs_col == COLS - 1) begin
                    crs_col = '0;
                    next_line();
                end else begin
                    crs_col++;
                end
            end
        end else if (c.rd_row < ROWS && c.rd_col < COLS) begin
            rep.ch   = scr_char[c.rd_row * COLS + c.rd_col];
            rep.attr = scr_attr[c.rd_row * COLS + c.rd_col];
        end
        rep.row = crs_row;
        rep.col = crs_col;
        rep.pos = 11'(int'(crs_row) * COLS + int'(crs_col));
        return rep;
    endfunction

    // driver: offers queued commands, predicts on every accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) cursor_reports_q.push_back(console_step(drv_cmd));
            if (!s_tvalid || s_tready) begin
                if (pending_cmds_q.size() != 0 && (no_gaps || $urandom_range(99) >= 23)) begin
                    drv_cmd = pending_cmds_q.pop_front();
                    s_tdata <= {4'b0, drv_cmd.rd_col, drv_cmd.rd_row, drv_cmd.code};
                    s_tuser <= drv_cmd.cmd;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks results, random back-pressure plus one long hold-off
    always @(posedge i_clk) begin
        t_cursor_report exp_rep;
        logic [4:0]     got_row;
        logic [6:0]     got_col;
        logic [10:0]    got_pos;
        logic [7:0]     got_ch;
        logic [7:0]     got_attr;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                {got_attr, got_ch, got_pos, got_col, got_row} = m_tdata[38:0];
                results_seen++;
                if (cursor_reports_q.size() == 0) begin
                    flag_error("result with nothing expected");
                end else begin
                    exp_rep = cursor_reports_q.pop_front();
                    if (got_row !== exp_rep.row)
                        flag_error($sformatf("cursor_row got %0d exp %0d", got_row, exp_rep.row));
                    if (got_col !== exp_rep.col)
                        flag_error($sformatf("cursor_col got %0d exp %0d", got_col, exp_rep.col));
                    if (got_pos !== exp_rep.pos)
                        flag_error($sformatf("cursor_position got %0d exp %0d",
                                             got_pos, exp_rep.pos));
                    if (got_ch !== exp_rep.ch)
                        flag_error($sformatf("cell_char got %h exp %h", got_ch, exp_rep.ch));
                    if (got_attr !== exp_rep.attr)
                        flag_error($sformatf("cell_attr got %h exp %h", got_attr, exp_rep.attr));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && results_seen >= 300) begin
                hold_done = 1'b1;
                hold_left = 200;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_gaps || ($urandom_range(99) >= 23);
            end
        end
    end

    task automatic push_put(logic [7:0] code);
        t_console_cmd c;
        c.cmd    = CMD_PUT;
        c.code   = code;
        c.rd_row = 5'($urandom_range(31));
        c.rd_col = 7'($urandom_range(127));
        pending_cmds_q.push_back(c);
    endtask

    task automatic push_read(int r, int col);
        t_console_cmd c;
        c.cmd    = CMD_READ;
        c.code   = 8'($urandom_range(255));
        c.rd_row = 5'(r);
        c.rd_col = 7'(col);
        pending_cmds_q.push_back(c);
    endtask

    task automatic push_random_cmd();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            // mostly in range, sometimes past the screen edge
            push_read(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(ROWS - 1),
                      ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(COLS - 1));
        end else if (pick < 30) begin
            push_put($urandom_range(1) ? CH_NL : CH_CR);
        end else if (pick < 36) begin
            push_put(CH_TAB);
        end else if (pick < 42) begin
            push_put(CH_BS);
        end else begin
            push_put(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_cmds_q.size() != 0 || cursor_reports_q.size() != 0 || s_tvalid || !s_tready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ATTR) attr_reg = val;
        else if (idx == CFG_TAB) tab_reg = val[6:0];
    endtask

    logic [7:0] phase_attr [5] = '{8'h07, 8'h00, 8'hFF, 8'h1E, 8'h4F};
    logic [7:0] phase_tab  [5] = '{8'd4, 8'd1, 8'd79, 8'd0, 8'd13};

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            scr_char[i] = BLANK_CHAR;
            scr_attr[i] = RESET_ATTR;
        end
        crs_row  = '0;
        crs_col  = '0;
        attr_reg = RESET_ATTR;
        tab_reg  = RESET_TAB;

        for (int ph = 0; ph < 5; ph++) begin
            // sender holds here until every result of the previous phase is back
            wait_idle();
            write_reg(CFG_ATTR, phase_attr[ph]);
            write_reg(CFG_TAB, phase_tab[ph]);
            no_gaps = (ph == 2);
            if (ph == 0) begin
                push_read(0, 0);
                push_read(ROWS - 1, COLS - 1);
                push_read(ROWS, 0);
                push_read(0, COLS);
                push_read(31, 127);
                push_put(CH_BS);        // backspace at home: floor at row 0, goes to last column
                push_read(0, COLS - 1);
                push_put(8'h5A);        // written in last column, wraps to next row
                push_put(CH_BS);        // backspace at column 0 climbs to row above
                push_put(8'h00);
                push_put(8'hFF);
                push_put(8'h0E);
                push_put(8'h0F);
                push_put(CH_TAB);
                push_read(1, 0);
                push_read(0, COLS - 1);
                push_put(CH_NL);
                push_put(CH_CR);
                // walk down to the bottom row so later traffic scrolls
                for (int i = 0; i < ROWS - 2; i++) push_put(CH_NL);
                push_read(ROWS - 1, 0);
                push_read(ROWS - 2, 0);
            end else if (ph == 3) begin
                // zero tab width keeps the column
                push_put(8'h41);
                push_put(CH_TAB);
                push_put(CH_TAB);
            end else if (ph == 2) begin
                push_put(CH_CR);
                push_put(8'h42);
                push_put(CH_TAB);
                push_put(CH_TAB);
            end
            for (int i = 0; i < 200; i++) push_random_cmd();
        end
        wait_idle();
        no_gaps = 1'b0;
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/txcon_pkg.sv
rtl/core/text_console_engine.sv
rtl/core/txcon_checker.sv
test/tb_text_console_engine.sv
